>>> hw/rtl/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; every other file of the block imports this package.
package pva_pkg;

	localparam int VOICES      = 64;
	localparam int VOICE_W     = 6;
	localparam int COUNT_W     = 7;
	localparam int NOTE_W      = 7;
	localparam int BLK_W       = 13;
	localparam int REL_W       = 20;

	localparam logic [BLK_W-1:0]   MAX_BLOCK          = 13'd4096;
	localparam logic [NOTE_W-1:0]  SUSTAIN_CONTROLLER = 7'd64;
	localparam logic [NOTE_W-1:0]  PEDAL_THRESHOLD    = 7'h40;
	localparam logic [REL_W-1:0]   RELEASE_RESET      = 20'd7200;
	localparam logic [COUNT_W-1:0] VOICE_COUNT        = 7'd64;

	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_CONTROL  = 2'd2,
		OP_TICK     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_STARTED = 2'd0,
		KIND_NO_FREE = 2'd1,
		KIND_RENDER  = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ON   = 2'd1,
		MODE_REL  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_NOTE_ON,
		S_LIST,
		S_VOICE,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [NOTE_W-1:0] note;
		logic [NOTE_W-1:0] velocity;
		logic [NOTE_W-1:0] controller;
		logic [NOTE_W-1:0] control_value;
		logic [BLK_W-1:0]  block_len;
	} pva_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VOICE_W-1:0] voice;
		logic [NOTE_W-1:0]  note_out;
		logic [NOTE_W-1:0]  velocity_out;
		logic [BLK_W-1:0]   render_len;
		logic [REL_W-1:0]   release_left;
		logic               freed;
		logic               last;
	} pva_out_t;

	typedef struct packed {
		mode_t             mode;
		logic              sustained;
		logic [NOTE_W-1:0] note;
		logic [NOTE_W-1:0] velocity;
		logic [REL_W-1:0]  release_left;
	} voice_rec_t;

endpackage

>>> hw/rtl/pva_list_mem.sv
// Active voice list: 64 entries of voice indexes, one write and two read ports.
// Depends on pva_pkg.
module pva_list_mem
	import pva_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [VOICE_W-1:0] wr_addr,
	input  logic [VOICE_W-1:0] wr_data,
	input  logic [VOICE_W-1:0] rd_addr_a,
	output logic [VOICE_W-1:0] rd_data_a,
	input  logic [VOICE_W-1:0] rd_addr_b,
	output logic [VOICE_W-1:0] rd_data_b
);

	logic [VOICE_W-1:0] mem [VOICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

>>> hw/rtl/pva_voice_mem.sv
// Per-voice record memory: mode, sustain mark, note, velocity, release count.
// Depends on pva_pkg.
module pva_voice_mem
	import pva_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [VOICE_W-1:0] wr_addr,
	input  voice_rec_t         wr_data,
	input  logic [VOICE_W-1:0] rd_addr,
	output voice_rec_t         rd_data
);

	voice_rec_t mem [VOICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/pva_idle_stack.sv
// Idle voice stack memory. An entry never written since reset reads as its
// own index, which gives the reset order of voices. Depends on pva_pkg.
module pva_idle_stack
	import pva_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [VOICE_W-1:0] wr_addr,
	input  logic [VOICE_W-1:0] wr_data,
	input  logic [VOICE_W-1:0] rd_addr,
	output logic [VOICE_W-1:0] rd_data
);

	logic [VOICE_W-1:0] mem [VOICES];
	logic [VOICES-1:0]  written_q;
	logic [VOICE_W-1:0] data_q;
	logic [VOICE_W-1:0] addr_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
		addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			hit_q <= written_q[rd_addr];
		end
	end

	assign rd_data = hit_q ? data_q : addr_q;

endmodule

>>> hw/rtl/polyphonic_voice_allocator_unit.sv
// Polyphonic voice allocator, top level.
// Depends on pva_pkg, pva_list_mem, pva_voice_mem and pva_idle_stack.
//
// Usage: a command is taken when start is high and busy is low; the fields
// of cmd are captured in that cycle. Results appear on result for exactly one
// cycle each, marked by result_valid; the receiver cannot hold them off.
// The release length register is written through cfg_valid/cfg_ready/cfg_data
// and is always ready; write it only while busy is low.
//
// Timing: a note-on with no free voice reports in the cycle after the
// transfer and leaves busy low. A note-on that gets a voice is busy through
// S_POP and S_NOTE_ON and reports in the cycle after them. Note-off, sustain
// controller and tick walk the active list, each active voice in turn by a
// list read, a voice record read, then update and write back, so such a
// command keeps busy high until every active voice is visited, and not at
// all with none; other controllers never raise busy. A tick gives one result
// per voice in the cycle after each visit, the last one flagged by last;
// note-off and controller give no result.
// Reset: all voices idle in the stack, pedal up, release length 7200. No
// clearing pass is needed; the block takes commands right after reset.
module polyphonic_voice_allocator_unit
	import pva_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pva_in_t          cmd,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [REL_W-1:0] cfg_data,
	output logic             result_valid,
	output pva_out_t         result
);

	state_t             state_q, state_d;
	pva_in_t            cmd_q;
	logic [REL_W-1:0]   release_samples_q;
	logic [COUNT_W-1:0] idle_cnt_q;
	logic [COUNT_W-1:0] active_cnt_q;
	logic [COUNT_W-1:0] visits_q;
	logic [VOICE_W-1:0] pos_q;
	logic [VOICE_W-1:0] voice_q;
	logic               pedal_q;
	logic               result_valid_q;
	pva_out_t           result_q;

	logic               list_we;
	logic [VOICE_W-1:0] list_waddr, list_wdata, list_raddr_a, list_raddr_b;
	logic [VOICE_W-1:0] list_rdata_a, list_rdata_b;
	logic               voice_we;
	logic [VOICE_W-1:0] voice_waddr, voice_raddr;
	voice_rec_t         voice_wdata, voice_rdata;
	logic               idle_we;
	logic [VOICE_W-1:0] idle_waddr, idle_raddr, idle_rdata;
	logic [VOICE_W-1:0] idle_wdata_w;

	logic [COUNT_W-1:0] idle_top, active_top;
	logic [BLK_W-1:0]   blk;
	logic [REL_W-1:0]   blk_ext, rel_len;
	logic               rel_done;
	logic               free_now;
	voice_rec_t         upd_rec;
	pva_out_t           walk_res;

	pva_list_mem u_list (
		.clk       (clk),
		.wr_en     (list_we),
		.wr_addr   (list_waddr),
		.wr_data   (list_wdata),
		.rd_addr_a (list_raddr_a),
		.rd_data_a (list_rdata_a),
		.rd_addr_b (list_raddr_b),
		.rd_data_b (list_rdata_b)
	);

	pva_voice_mem u_voice (
		.clk     (clk),
		.wr_en   (voice_we),
		.wr_addr (voice_waddr),
		.wr_data (voice_wdata),
		.rd_addr (voice_raddr),
		.rd_data (voice_rdata)
	);

	pva_idle_stack u_idle (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (idle_we),
		.wr_addr (idle_waddr),
		.wr_data (idle_wdata_w),
		.rd_addr (idle_raddr),
		.rd_data (idle_rdata)
	);

	assign idle_wdata_w = voice_q;

	assign idle_top   = idle_cnt_q - 7'd1;
	assign active_top = active_cnt_q - 7'd1;
	assign blk        = (cmd_q.block_len > MAX_BLOCK) ? MAX_BLOCK : cmd_q.block_len;
	assign blk_ext    = {{(REL_W-BLK_W){1'b0}}, blk};
	assign rel_done   = voice_rdata.release_left < blk_ext;
	assign rel_len    = rel_done ? voice_rdata.release_left : blk_ext;

	// Update of one visited voice record, by command.
	always_comb begin
		upd_rec  = voice_rdata;
		free_now = 1'b0;
		walk_res = '0;
		walk_res.voice        = voice_q;
		walk_res.note_out     = voice_rdata.note;
		walk_res.velocity_out = voice_rdata.velocity;
		walk_res.last         = (visits_q == 7'd1);
		case (cmd_q.opcode)
			OP_NOTE_OFF: begin
				if (voice_rdata.mode == MODE_ON && voice_rdata.note == cmd_q.note) begin
					if (pedal_q) begin
						upd_rec.sustained = 1'b1;
					end else begin
						upd_rec.mode         = MODE_REL;
						upd_rec.release_left = release_samples_q;
					end
				end
			end
			OP_CONTROL: begin
				// Only a pedal lift lets the sustained voices go.
				if (!pedal_q && voice_rdata.sustained && voice_rdata.mode == MODE_ON) begin
					upd_rec.mode         = MODE_REL;
					upd_rec.release_left = release_samples_q;
				end
			end
			OP_TICK: begin
				if (voice_rdata.mode == MODE_REL) begin
					walk_res.kind         = KIND_RELEASE;
					walk_res.render_len   = rel_len[BLK_W-1:0];
					walk_res.release_left = voice_rdata.release_left;
					walk_res.freed        = rel_done;
					upd_rec.release_left  = voice_rdata.release_left - rel_len;
					if (rel_done) begin
						upd_rec.mode      = MODE_IDLE;
						upd_rec.sustained = 1'b0;
						free_now          = 1'b1;
					end
				end else begin
					walk_res.kind       = KIND_RENDER;
					walk_res.render_len = blk;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state and memory port control.
	always_comb begin
		state_d      = state_q;
		list_we      = 1'b0;
		list_waddr   = pos_q;
		list_wdata   = list_rdata_b;
		list_raddr_a = pos_q;
		list_raddr_b = active_top[VOICE_W-1:0];
		voice_we     = 1'b0;
		voice_waddr  = voice_q;
		voice_wdata  = upd_rec;
		voice_raddr  = list_rdata_a;
		idle_we      = 1'b0;
		idle_waddr   = idle_cnt_q[VOICE_W-1:0];
		idle_raddr   = idle_top[VOICE_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.opcode)
						OP_NOTE_ON: begin
							if (idle_cnt_q != 7'd0) begin
								state_d = S_POP;
							end
						end
						default: begin
							if (active_cnt_q != 7'd0 &&
							    (cmd.opcode != OP_CONTROL ||
							     cmd.controller == SUSTAIN_CONTROLLER)) begin
								state_d = S_LIST;
							end
						end
					endcase
				end
			end
			S_POP: begin
				state_d = S_NOTE_ON;
			end
			S_NOTE_ON: begin
				list_we     = 1'b1;
				list_waddr  = active_cnt_q[VOICE_W-1:0];
				list_wdata  = idle_rdata;
				voice_we    = 1'b1;
				voice_waddr = idle_rdata;
				voice_wdata = '{mode: MODE_ON, sustained: 1'b0, note: cmd_q.note,
				                velocity: cmd_q.velocity, release_left: '0};
				state_d     = S_IDLE;
			end
			S_LIST: begin
				state_d = S_VOICE;
			end
			S_VOICE: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				voice_we = 1'b1;
				list_we  = free_now;
				idle_we  = free_now;
				state_d  = (visits_q == 7'd1) ? S_IDLE : S_LIST;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_samples_q <= RELEASE_RESET;
			idle_cnt_q        <= VOICE_COUNT;
			active_cnt_q      <= '0;
			visits_q          <= '0;
			pos_q             <= '0;
			pedal_q           <= 1'b0;
			result_valid_q    <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				release_samples_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pos_q    <= '0;
						visits_q <= active_cnt_q;
						if (cmd.opcode == OP_NOTE_ON && idle_cnt_q == 7'd0) begin
							result_valid_q <= 1'b1;
						end
						if (cmd.opcode == OP_CONTROL && cmd.controller == SUSTAIN_CONTROLLER) begin
							pedal_q <= cmd.control_value > PEDAL_THRESHOLD;
						end
					end
				end
				S_NOTE_ON: begin
					idle_cnt_q     <= idle_top;
					active_cnt_q   <= active_cnt_q + 7'd1;
					result_valid_q <= 1'b1;
				end
				S_UPDATE: begin
					visits_q <= visits_q - 7'd1;
					if (cmd_q.opcode == OP_TICK) begin
						result_valid_q <= 1'b1;
					end
					if (free_now) begin
						active_cnt_q <= active_top;
						idle_cnt_q   <= idle_cnt_q + 7'd1;
					end else begin
						pos_q <= pos_q + 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q    <= cmd;
					result_q <= '{kind: KIND_NO_FREE, voice: '0, note_out: '0,
					              velocity_out: '0, render_len: '0,
					              release_left: '0, freed: 1'b0, last: 1'b0};
				end
			end
			S_VOICE: begin
				voice_q <= list_rdata_a;
			end
			S_NOTE_ON: begin
				result_q <= '{kind: KIND_STARTED, voice: idle_rdata, note_out: cmd_q.note,
				              velocity_out: cmd_q.velocity, render_len: '0,
				              release_left: '0, freed: 1'b0, last: 1'b0};
			end
			S_UPDATE: begin
				result_q <= walk_res;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(idle_cnt_q + active_cnt_q) == VOICE_COUNT)
		else $error("idle and active voice counts do not add up");

	a_no_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_NO_FREE) |-> (idle_cnt_q == 7'd0))
		else $error("no-free report while idle voices remain");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> !busy)
		else $error("last result while the walk continues");
`endif

endmodule
